[rtl/core/sprite_affine_setup_top_defines.svh]
// ----------------------------------------------------------------------------
// sprite affine setup assertion macros
// concurrent checks on clk, dropped from synthesis builds
// ----------------------------------------------------------------------------
`ifndef SPRITE_AFFINE_SETUP_TOP_DEFINES_SVH
`define SPRITE_AFFINE_SETUP_TOP_DEFINES_SVH

`ifndef SYNTH
// check that is ignored while reset is asserted
`define SAS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define SAS_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAS_ASSERT(name, prop, msg)
`define SAS_ASSERT_RST(name, prop, msg)
`endif

`endif

[rtl/core/sas_pkg.sv]
// ----------------------------------------------------------------------------
// sprite affine setup package
// shared types, cordic constants and the arctangent table
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CELLS         = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    localparam int STAGE_W       = $clog2(ATAN_ENTRIES);

    // reciprocal of the infinite-stage cordic gain, in q30
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [23:0]        width;
        logic [23:0]        height;
        logic signed [15:0] origin_u;
        logic signed [15:0] origin_v;
        logic [1:0]         quad;
        logic               zero;
    } sprite_t;

    typedef struct packed {
        sprite_t            spr;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cell_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [31:0] atan_turns(input logic [STAGE_W-1:0] idx);
        logic signed [31:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/sas_cordic_cell.sv]
// ----------------------------------------------------------------------------
// sprite affine setup cordic cell
// one rotation step with its own register slice and valid/ready hand-off
// ----------------------------------------------------------------------------
module sas_cordic_cell
    import sas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [STAGE_W-1:0] stage,
    input  logic               in_valid,
    output logic               in_ready,
    input  cell_t              in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cell_t              out_data
);

    logic               valid_reg;
    logic               valid_next;
    cell_t              data_reg;
    cell_t              data_next;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] atan;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        dx         = in_data.y >>> stage;
        dy         = in_data.x >>> stage;
        atan       = atan_turns(stage);
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = data_reg;
        if (in_ready)
        begin
            data_next.spr = in_data.spr;
            // turn toward the residual angle
            if (!in_data.z[31])
            begin
                data_next.x = in_data.x - dx;
                data_next.y = in_data.y + dy;
                data_next.z = in_data.z - atan;
            end
            else
            begin
                data_next.x = in_data.x + dx;
                data_next.y = in_data.y - dy;
                data_next.z = in_data.z + atan;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

[rtl/core/sas_frame.sv]
// ----------------------------------------------------------------------------
// sprite affine setup frame stages
// quadrant fix-up, axis scaling, pivot and translation, five register stages
// ----------------------------------------------------------------------------
`include "sprite_affine_setup_top_defines.svh"

module sas_frame
    import sas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cell_t              in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [24:0] xaxis_x,
    output logic signed [24:0] xaxis_y,
    output logic signed [24:0] yaxis_x,
    output logic signed [24:0] yaxis_y,
    output logic signed [31:0] shift_x,
    output logic signed [31:0] shift_y
);

    // round half up from q30 and clamp to the 25-bit axis range
    function automatic logic signed [24:0] scale_round(input logic signed [56:0] p,
                                                       input logic neg);
        logic signed [57:0] t;
        logic signed [27:0] r;
        logic signed [24:0] o;
        t = neg ? -{p[56], p} : {p[56], p};
        t = t + 58'sd536870912;
        r = t[57:30];
        if (r > 28'sd16777215)
            o = 25'sd16777215;
        else if (r < -28'sd16777216)
            o = -25'sd16777216;
        else
            o = r[24:0];
        return o;
    endfunction

    logic s1_en, s2_en, s3_en, s4_en, s5_en;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    // stage 1: trig times extent
    logic signed [31:0] cos_v, sin_v;
    logic signed [24:0] w_ext, h_ext;
    logic signed [56:0] s1_cw_reg, s1_sw_reg, s1_sh_reg, s1_ch_reg;
    logic signed [56:0] s1_cw_next, s1_sw_next, s1_sh_next, s1_ch_next;
    sprite_t            s1_spr_reg;

    // stage 2: axes
    logic signed [24:0] s2_xx_reg, s2_xy_reg, s2_yx_reg, s2_yy_reg;
    logic signed [24:0] s2_xx_next, s2_xy_next, s2_yx_next, s2_yy_next;
    sprite_t            s2_spr_reg;

    // stage 3: pivot products
    logic signed [40:0] s3_xu_reg, s3_yv_reg, s3_xyu_reg, s3_yyv_reg;
    logic signed [24:0] s3_xx_reg, s3_xy_reg, s3_yx_reg, s3_yy_reg;
    logic signed [23:0] s3_px_reg, s3_py_reg;

    // stage 4: pivots
    logic signed [41:0] sum_x, sum_y;
    logic signed [27:0] s4_pvx_reg, s4_pvy_reg;
    logic signed [24:0] s4_xx_reg, s4_xy_reg, s4_yx_reg, s4_yy_reg;
    logic signed [23:0] s4_px_reg, s4_py_reg;

    // stage 5: translation, output register
    logic signed [28:0] diff_x, diff_y;
    logic signed [24:0] s5_xx_reg, s5_xy_reg, s5_yx_reg, s5_yy_reg;
    logic signed [31:0] s5_sx_reg, s5_sy_reg;

    assign s5_en    = !s5_valid_reg || out_ready;
    assign s4_en    = !s4_valid_reg || s5_en;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_comb
    begin
        case (in_data.spr.quad)
            QUAD_0:
            begin
                cos_v = in_data.x;
                sin_v = in_data.y;
            end
            QUAD_1:
            begin
                cos_v = -in_data.y;
                sin_v = in_data.x;
            end
            QUAD_2:
            begin
                cos_v = -in_data.x;
                sin_v = -in_data.y;
            end
            QUAD_3:
            begin
                cos_v = in_data.y;
                sin_v = -in_data.x;
            end
            default:
            begin
                cos_v = in_data.x;
                sin_v = in_data.y;
            end
        endcase
        w_ext      = {1'b0, in_data.spr.width};
        h_ext      = {1'b0, in_data.spr.height};
        s1_cw_next = cos_v * w_ext;
        s1_sw_next = sin_v * w_ext;
        s1_sh_next = sin_v * h_ext;
        s1_ch_next = cos_v * h_ext;
    end

    always_comb
    begin
        if (s1_spr_reg.zero)
        begin
            // zero angle ignores the rotator result: exact axes
            s2_xx_next = {1'b0, s1_spr_reg.width};
            s2_xy_next = '0;
            s2_yx_next = '0;
            s2_yy_next = {1'b0, s1_spr_reg.height};
        end
        else
        begin
            s2_xx_next = scale_round(s1_cw_reg, 1'b0);
            s2_xy_next = scale_round(s1_sw_reg, 1'b0);
            s2_yx_next = scale_round(s1_sh_reg, 1'b1);
            s2_yy_next = scale_round(s1_ch_reg, 1'b0);
        end
    end

    always_comb
    begin
        sum_x  = 42'(s3_xu_reg) + 42'(s3_yv_reg) + 42'sd8192;
        sum_y  = 42'(s3_xyu_reg) + 42'(s3_yyv_reg) + 42'sd8192;
        // pivot magnitude is at most 2^26, so the difference fits 32 bits and needs no clamp
        diff_x = 29'(s4_px_reg) - 29'(s4_pvx_reg);
        diff_y = 29'(s4_py_reg) - 29'(s4_pvy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
            if (s4_en)
                s4_valid_reg <= s3_valid_reg;
            if (s5_en)
                s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_cw_reg  <= s1_cw_next;
            s1_sw_reg  <= s1_sw_next;
            s1_sh_reg  <= s1_sh_next;
            s1_ch_reg  <= s1_ch_next;
            s1_spr_reg <= in_data.spr;
        end
        if (s2_en)
        begin
            s2_xx_reg  <= s2_xx_next;
            s2_xy_reg  <= s2_xy_next;
            s2_yx_reg  <= s2_yx_next;
            s2_yy_reg  <= s2_yy_next;
            s2_spr_reg <= s1_spr_reg;
        end
        if (s3_en)
        begin
            s3_xu_reg  <= s2_xx_reg * s2_spr_reg.origin_u;
            s3_yv_reg  <= s2_yx_reg * s2_spr_reg.origin_v;
            s3_xyu_reg <= s2_xy_reg * s2_spr_reg.origin_u;
            s3_yyv_reg <= s2_yy_reg * s2_spr_reg.origin_v;
            s3_xx_reg  <= s2_xx_reg;
            s3_xy_reg  <= s2_xy_reg;
            s3_yx_reg  <= s2_yx_reg;
            s3_yy_reg  <= s2_yy_reg;
            s3_px_reg  <= s2_spr_reg.pos_x;
            s3_py_reg  <= s2_spr_reg.pos_y;
        end
        if (s4_en)
        begin
            s4_pvx_reg <= sum_x[41:14];
            s4_pvy_reg <= sum_y[41:14];
            s4_xx_reg  <= s3_xx_reg;
            s4_xy_reg  <= s3_xy_reg;
            s4_yx_reg  <= s3_yx_reg;
            s4_yy_reg  <= s3_yy_reg;
            s4_px_reg  <= s3_px_reg;
            s4_py_reg  <= s3_py_reg;
        end
        if (s5_en)
        begin
            s5_sx_reg <= 32'(diff_x);
            s5_sy_reg <= 32'(diff_y);
            s5_xx_reg <= s4_xx_reg;
            s5_xy_reg <= s4_xy_reg;
            s5_yx_reg <= s4_yx_reg;
            s5_yy_reg <= s4_yy_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign xaxis_x   = s5_xx_reg;
    assign xaxis_y   = s5_xy_reg;
    assign yaxis_x   = s5_yx_reg;
    assign yaxis_y   = s5_yy_reg;
    assign shift_x   = s5_sx_reg;
    assign shift_y   = s5_sy_reg;

    `SAS_ASSERT_RST(a_reset_empty, !rst_n |-> !s5_valid_reg && !s1_valid_reg, "valid during reset")
    `SAS_ASSERT(a_beat_moves, s1_valid_reg && s2_en |=> s2_valid_reg, "beat lost between stages")
    `SAS_ASSERT(a_stall_holds, s2_valid_reg && !s3_en |=> $stable(s2_xx_reg), "stalled axis changed")
    `SAS_ASSERT(a_zero_axes, s2_valid_reg && s2_spr_reg.zero |-> s2_xy_reg == 0 && s2_yx_reg == 0, "zero angle axis not exact")

endmodule

[rtl/core/sprite_affine_setup_top.sv]
// ----------------------------------------------------------------------------
// sprite affine setup top
// sprite description in, scaled rotated axes and translation out
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one sprite per beat: position,
//   extents, origin fractions and a 16-bit binary angle
//   output channel out_valid/out_ready carries the affine frame: both axes
//   and the translation
//   the rotator chain has one register slice per cordic cell (CELLS, 16
//   here), then five stages follow for quadrant fix-up and extent
//   products, rounding, pivot products, pivot sum, translation
//   throughput is one sprite per cycle; every stage is a single register
//   slice, so a new beat enters each cycle while the chain moves
//   when the receiver stalls, the output register holds and stalled stages
//   fill from the back; in_ready drops only once the bubble ahead of the
//   input is gone
//   reset clears all valid flags; no result is pending after reset
// ----------------------------------------------------------------------------
module sprite_affine_setup_top
    import sas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic [23:0]        width,
    input  logic [23:0]        height,
    input  logic signed [15:0] origin_u,
    input  logic signed [15:0] origin_v,
    input  logic [15:0]        angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [24:0] xaxis_x,
    output logic signed [24:0] xaxis_y,
    output logic signed [24:0] yaxis_x,
    output logic signed [24:0] yaxis_y,
    output logic signed [31:0] shift_x,
    output logic signed [31:0] shift_y
);

    logic  [15:0] angle_bias;
    logic  [15:0] angle_rem;
    logic  [1:0]  quad;
    cell_t        chain_data  [0:CELLS];
    logic         chain_valid [0:CELLS];
    logic         chain_ready [0:CELLS];

    // take out the nearest quarter turn, the rest goes to the rotator
    always_comb
    begin
        angle_bias               = angle + 16'h2000;
        quad                     = angle_bias[15:14];
        angle_rem                = angle - {quad, 14'd0};
        chain_data[0].spr.pos_x    = pos_x;
        chain_data[0].spr.pos_y    = pos_y;
        chain_data[0].spr.width    = width;
        chain_data[0].spr.height   = height;
        chain_data[0].spr.origin_u = origin_u;
        chain_data[0].spr.origin_v = origin_v;
        chain_data[0].spr.quad     = quad;
        chain_data[0].spr.zero     = (angle == 16'd0);
        chain_data[0].x            = CORDIC_GAIN;
        chain_data[0].y            = '0;
        chain_data[0].z            = {angle_rem, 16'd0};
    end

    assign chain_valid[0] = in_valid;
    assign in_ready       = chain_ready[0];

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        sas_cordic_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (STAGE_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    sas_frame u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CELLS]),
        .in_ready  (chain_ready[CELLS]),
        .in_data   (chain_data[CELLS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .xaxis_x   (xaxis_x),
        .xaxis_y   (xaxis_y),
        .yaxis_x   (yaxis_x),
        .yaxis_y   (yaxis_y),
        .shift_x   (shift_x),
        .shift_y   (shift_y)
    );

endmodule

[tb/sprite_affine_setup_top_tb.sv]
// ----------------------------------------------------------------------------
// sprite affine setup testbench
// drives sprite beats through the valid/ready input with random gaps, stalls
// the output at random, and checks every affine frame against typed-in values or a
// cycle-free cordic predictor; a short directed table comes first, then random sprites
// ----------------------------------------------------------------------------
module sprite_affine_setup_top_tb;
    import sas_pkg::*;

    typedef struct {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [23:0]        width;
        logic [23:0]        height;
        logic signed [15:0] origin_u;
        logic signed [15:0] origin_v;
        logic [15:0]        angle;
    } sprite_in_t;

    typedef struct {
        logic signed [24:0] xaxis_x;
        logic signed [24:0] xaxis_y;
        logic signed [24:0] yaxis_x;
        logic signed [24:0] yaxis_y;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
    } frame_t;

    typedef struct {
        sprite_in_t spr;
        bit         typed;
        frame_t     want;
    } sprite_row_t;

    localparam int  RANDOM_SPRITES = 1900;
    localparam int  DRAIN_CYCLES   = 40;
    localparam int  MAX_ATAN       = 24;
    localparam longint UNIT_GAIN_Q30 = 64'sd652032874;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic out_valid;
    logic out_ready;
    logic signed [24:0] xaxis_x;
    logic signed [24:0] xaxis_y;
    logic signed [24:0] yaxis_x;
    logic signed [24:0] yaxis_y;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;

    sprite_in_t  cur_spr;
    bit          cur_typed;
    frame_t      cur_frame;
    bit          steady;
    int          errors;
    frame_t      pending_frames[$];
    sprite_row_t directed_rows[$];

    sprite_affine_setup_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_x     (cur_spr.pos_x),
        .pos_y     (cur_spr.pos_y),
        .width     (cur_spr.width),
        .height    (cur_spr.height),
        .origin_u  (cur_spr.origin_u),
        .origin_v  (cur_spr.origin_v),
        .angle     (cur_spr.angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .xaxis_x   (xaxis_x),
        .xaxis_y   (xaxis_y),
        .yaxis_x   (yaxis_x),
        .yaxis_y   (yaxis_y),
        .shift_x   (shift_x),
        .shift_y   (shift_y)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic longint arctan_turn(input int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            23: return 64'h00000051;
            default: return 64'h0;
        endcase
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // q30 cosine and sine of a binary angle
    function automatic void cordic_sincos(input logic [15:0] ang, output longint c,
                                          output longint s);
        logic [16:0] biased;
        logic [1:0]  quad;
        logic [15:0] rest;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        int          n;
        biased = {1'b0, ang} + 17'h02000;
        quad   = biased[15:14];
        rest   = ang - {quad, 14'b0};
        z      = $signed(rest);
        z      = z * 65536;
        x      = UNIT_GAIN_Q30;
        y      = 0;
        n      = (CORDIC_STAGES < MAX_ATAN) ? CORDIC_STAGES : MAX_ATAN;
        for (int i = 0; i < n; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_turn(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_turn(i);
            end
        end
        case (quad)
            QUAD_0:  begin c = x;  s = y;  end
            QUAD_1:  begin c = -y; s = x;  end
            QUAD_2:  begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic longint scale_extent(input longint trig, input longint extent);
        longint p;
        p = trig * extent + (64'sd1 <<< 29);
        return clamp_to(p >>> 30, -64'sd16777216, 64'sd16777215);
    endfunction

    function automatic longint pivot_shift(input longint pos, input longint au, input longint av,
                                           input longint ou, input longint ov);
        longint sum;
        sum = au * ou + av * ov + 64'sd8192;
        return clamp_to(pos - (sum >>> 14), -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic frame_t predict_frame(input sprite_in_t s);
        longint c;
        longint sn;
        longint w;
        longint h;
        longint xx;
        longint xy;
        longint yx;
        longint yy;
        frame_t f;
        w = s.width;
        h = s.height;
        if (s.angle == 16'd0)
        begin
            xx = w;
            xy = 0;
            yx = 0;
            yy = h;
        end
        else
        begin
            cordic_sincos(s.angle, c, sn);
            xx = scale_extent(c, w);
            xy = scale_extent(sn, w);
            yx = scale_extent(-sn, h);
            yy = scale_extent(c, h);
        end
        f.xaxis_x = xx[24:0];
        f.xaxis_y = xy[24:0];
        f.yaxis_x = yx[24:0];
        f.yaxis_y = yy[24:0];
        f.shift_x = 32'(pivot_shift(s.pos_x, xx, yx, s.origin_u, s.origin_v));
        f.shift_y = 32'(pivot_shift(s.pos_y, xy, yy, s.origin_u, s.origin_v));
        return f;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_row(input int px, input int py, input int w, input int h,
                           input int ou, input int ov, input int ang,
                           input bit typed = 1'b0,
                           input longint xx = 0, input longint xy = 0,
                           input longint yx = 0, input longint yy = 0,
                           input longint sx = 0, input longint sy = 0);
        sprite_row_t r;
        r.spr.pos_x      = 24'(px);
        r.spr.pos_y      = 24'(py);
        r.spr.width      = 24'(w);
        r.spr.height     = 24'(h);
        r.spr.origin_u   = 16'(ou);
        r.spr.origin_v   = 16'(ov);
        r.spr.angle      = 16'(ang);
        r.typed          = typed;
        r.want.xaxis_x   = xx[24:0];
        r.want.xaxis_y   = xy[24:0];
        r.want.yaxis_x   = yx[24:0];
        r.want.yaxis_y   = yy[24:0];
        r.want.shift_x   = sx[31:0];
        r.want.shift_y   = sy[31:0];
        directed_rows.push_back(r);
    endtask

    function automatic logic [23:0] rand_extent();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1:    return 24'($urandom_range(255));
            2:       return 24'hFFFFFF;
            3:       return 24'h0;
            4:       return 24'($urandom_range(65535));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_origin();
        int pick;
        pick = $urandom_range(15);
        case (pick)
            0:       return 16'sh0000;
            1:       return 16'sh4000;
            2:       return 16'sh2000;
            3:       return -16'sh8000;
            4:       return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [23:0] rand_pos();
        int pick;
        pick = $urandom_range(15);
        case (pick)
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return 24'sh000000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        int pick;
        logic [15:0] base;
        pick = $urandom_range(9);
        base = 16'($urandom_range(3)) << 14;
        case (pick)
            0:       return 16'h0000;
            // around the quadrant split points
            1:       return base + 16'h2000 - 16'($urandom_range(2));
            // around the cardinal directions
            2:       return base + 16'($urandom_range(4)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sprite(input sprite_in_t s, input bit typed, input frame_t f);
        while (!steady && $urandom_range(99) < 16)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cur_spr   = s;
        cur_typed = typed;
        cur_frame = f;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            if (cur_typed)
                pending_frames.push_back(cur_frame);
            else
                pending_frames.push_back(predict_frame(cur_spr));
        end
    end

    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected frame, expected none actual shift %0d,%0d",
                         $time, shift_x, shift_y);
                errors++;
            end
            else
            begin
                want = pending_frames.pop_front();
                check_field("xaxis_x", want.xaxis_x, xaxis_x);
                check_field("xaxis_y", want.xaxis_y, xaxis_y);
                check_field("yaxis_x", want.yaxis_x, yaxis_x);
                check_field("yaxis_y", want.yaxis_y, yaxis_y);
                check_field("shift_x", want.shift_x, shift_x);
                check_field("shift_y", want.shift_y, shift_y);
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready = steady || ($urandom_range(99) >= 16);
    end

    initial
    begin
        #1000000;
        $display("[sprite_affine_setup_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        sprite_in_t s;
        frame_t     blank;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        steady    = 1'b0;
        errors    = 0;
        cur_typed = 1'b0;
        cur_spr   = '{24'sh0, 24'sh0, 24'h0, 24'h0, 16'sh0, 16'sh0, 16'h0};
        cur_frame = '{25'sh0, 25'sh0, 25'sh0, 25'sh0, 32'sh0, 32'sh0};
        blank     = cur_frame;

        // zero angle rows are exact and typed in
        add_row(0, 0, 0, 0, 0, 0, 0, 1'b1);
        add_row(8388607, -8388608, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 1'b1,
                16777215, 0, 0, 16777215, 8388607, -8388608);
        add_row(24'h1000, 24'h2000, 24'h300, 24'h500, 16'h4000, 16'h4000, 0, 1'b1,
                24'h300, 0, 0, 24'h500, 32'hD00, 32'h1B00);
        add_row(0, 0, 24'hFFFFFF, 24'hFFFFFF, -32768, 32767, 0, 1'b1,
                16777215, 0, 0, 16777215, 33554430, -33553406);
        // rotated rows, checked by the predictor
        add_row(0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 1);
        add_row(0, 0, 24'hFFFFFF, 24'hFFFFFF, 16'h4000, 16'h4000, 16'hFFFF);
        add_row(24'h100, 24'h200, 24'h4000, 24'h2000, 16'h2000, 16'h2000, 16'h1FFF);
        add_row(24'h100, 24'h200, 24'h4000, 24'h2000, 16'h2000, 16'h2000, 16'h2000);
        add_row(-5, 7, 24'hFFFFFF, 24'h1, 0, 16'h4000, 16'h4000);
        add_row(-8388608, 8388607, 24'hFFFFFF, 24'hFFFFFF, -32768, -32768, 16'h4000);
        add_row(8388607, 8388607, 24'hFFFFFF, 24'hFFFFFF, 32767, 32767, 16'h6000);
        add_row(0, 0, 24'h1234, 24'h5678, 16'h2000, 16'h2000, 16'h8000);
        add_row(0, 0, 24'hFFFFFF, 24'hFFFFFF, 16'h2000, 16'hE000, 16'h8000);
        add_row(1, -1, 24'h800, 24'h800, -16384, 16384, 16'hA000);
        add_row(0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 16'hC000);
        add_row(0, 0, 24'h00FF, 24'hFF00, 16'h1000, 16'h3000, 16'hDFFF);
        add_row(0, 0, 24'hABCDEF, 24'h123456, 16'h5555, 16'hAAAA, 16'hE000);
        add_row(-8388608, -8388608, 24'hFFFFFF, 24'hFFFFFF, 32767, -32768, 16'h7FFF);
        add_row(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 16'h7FFF, 16'h8000, 16'h0001);
        add_row(0, 0, 1, 1, 16'h2000, 16'h2000, 16'h1000);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_sprite(directed_rows[i].spr, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_SPRITES; n++)
        begin
            // a long stretch with both sides busy every cycle
            steady     = (n >= 800 && n < 1100);
            s.pos_x    = rand_pos();
            s.pos_y    = rand_pos();
            s.width    = rand_extent();
            s.height   = rand_extent();
            s.origin_u = rand_origin();
            s.origin_v = rand_origin();
            s.angle    = rand_angle();
            send_sprite(s, 1'b0, blank);
        end
        steady   = 1'b0;
        in_valid = 1'b0;

        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[sprite_affine_setup_top] OK");
        else
            $display("[sprite_affine_setup_top] ERROR");
        $finish;
    end

endmodule
